>>> hw/rtl/pin_entry_lockout_controller_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the PIN entry lockout controller
// ---------------------------------------------------------------------------
`ifndef PIN_ENTRY_LOCKOUT_CONTROLLER_UNIT_MACROS_SVH
`define PIN_ENTRY_LOCKOUT_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define PELC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PELC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/pelc_pkg.sv
// ---------------------------------------------------------------------------
// pelc_pkg
// Shared types and constants of the PIN entry lockout controller.
// ---------------------------------------------------------------------------
package pelc_pkg;

   localparam int DEF_CODE_DIGITS = 4;

   localparam int KIND_W   = 3;
   localparam int DIGIT_W  = 4;
   localparam int STATUS_W = 4;
   localparam int COUNT_W  = 5;
   localparam int LIMIT_W  = 8;
   localparam int WAIT_W   = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIGIT_W-1:0] MAX_DIGIT  = 4'd9;
   localparam logic [LIMIT_W-1:0] FAIL_SAT   = 8'hFF;

   localparam logic [LIMIT_W-1:0] RST_SOFT_LIMIT = 8'd4;
   localparam logic [LIMIT_W-1:0] RST_HARD_LIMIT = 8'd6;
   localparam logic [WAIT_W-1:0]  RST_SOFT_WAIT  = 24'd30000;
   localparam logic [WAIT_W-1:0]  RST_HARD_WAIT  = 24'd300000;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 3'd0,
      KIND_OPEN   = 3'd1,
      KIND_DIGIT  = 3'd2,
      KIND_ERASE  = 3'd3,
      KIND_CANCEL = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IGNORED   = 4'd0,
      ST_DIGIT     = 4'd1,
      ST_ERASED    = 4'd2,
      ST_CONFIRM   = 4'd3,
      ST_STORED    = 4'd4,
      ST_MISMATCH  = 4'd5,
      ST_UNLOCKED  = 4'd6,
      ST_WRONG     = 4'd7,
      ST_BLOCKED   = 4'd8,
      ST_CANCELLED = 4'd9,
      ST_OPENED    = 4'd10
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOFT_LIMIT = 2'd0,
      REG_HARD_LIMIT = 2'd1,
      REG_SOFT_WAIT  = 2'd2,
      REG_HARD_WAIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] soft_limit;
      logic [LIMIT_W-1:0] hard_limit;
      logic [WAIT_W-1:0]  soft_wait;
      logic [WAIT_W-1:0]  hard_wait;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  digits_entered;
      logic                locked_out;
      logic [WAIT_W-1:0]   wait_left;
      logic [LIMIT_W-1:0]  failures;
      logic                code_is_set;
      logic                session_live;
   } result_type;

endpackage

>>> hw/rtl/pelc_csr.sv
// ---------------------------------------------------------------------------
// pelc_csr
// Limit and lockout length registers, written over the csr channel.
// ---------------------------------------------------------------------------
module pelc_csr import pelc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WAIT_W-1:0]    csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SOFT_LIMIT: cfg_in.soft_limit = csr_wdata[LIMIT_W-1:0];
            REG_HARD_LIMIT: cfg_in.hard_limit = csr_wdata[LIMIT_W-1:0];
            REG_SOFT_WAIT:  cfg_in.soft_wait  = csr_wdata;
            REG_HARD_WAIT:  cfg_in.hard_wait  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soft_limit <= RST_SOFT_LIMIT;
         cfg_ff.hard_limit <= RST_HARD_LIMIT;
         cfg_ff.soft_wait  <= RST_SOFT_WAIT;
         cfg_ff.hard_wait  <= RST_HARD_WAIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hw/rtl/pelc_core.sv
// ---------------------------------------------------------------------------
// pelc_core
// Session, entry buffer, code store and lockout state with the step logic.
// ---------------------------------------------------------------------------
module pelc_core import pelc_pkg::*; #(
   parameter int CODE_DIGITS = DEF_CODE_DIGITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [KIND_W-1:0]  kind,
   input  logic [DIGIT_W-1:0] digit,
   input  logic               set_mode,
   input  cfg_type            cfg,
   output result_type         result
);

   localparam int CW = $clog2(CODE_DIGITS + 1);
   localparam int IW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam logic [CW-1:0] FULL_CNT = CW'(CODE_DIGITS);
   localparam logic [CW-1:0] LAST_CNT = CW'(CODE_DIGITS - 1);

   logic [DIGIT_W-1:0] stored_ff [CODE_DIGITS];
   logic [DIGIT_W-1:0] entry_ff  [CODE_DIGITS];
   logic [DIGIT_W-1:0] first_ff  [CODE_DIGITS];
   logic [DIGIT_W-1:0] cand      [CODE_DIGITS];

   logic               code_valid_ff, code_valid_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               confirm_ff, confirm_in;
   logic               mode_ff, mode_in;
   logic               open_ff, open_in;
   logic [LIMIT_W-1:0] fail_ff, fail_in;
   logic [WAIT_W-1:0]  wait_ff, wait_in;

   logic               write_entry, load_first, load_stored;
   logic               match_stored, match_first;
   logic [LIMIT_W-1:0] fail_inc;
   status_type         status;

   // the buffer as it stands once the last digit lands
   always_comb begin
      match_stored = 1'b1;
      match_first  = 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         cand[i] = (i == CODE_DIGITS - 1) ? digit : entry_ff[i];
         if (cand[i] != stored_ff[i]) begin
            match_stored = 1'b0;
         end
         if (cand[i] != first_ff[i]) begin
            match_first = 1'b0;
         end
      end
   end

   assign fail_inc = (fail_ff == FAIL_SAT) ? fail_ff : fail_ff + 8'd1;

   always_comb begin
      code_valid_in = code_valid_ff;
      count_in      = count_ff;
      confirm_in    = confirm_ff;
      mode_in       = mode_ff;
      open_in       = open_ff;
      fail_in       = fail_ff;
      wait_in       = wait_ff;
      write_entry   = 1'b0;
      load_first    = 1'b0;
      load_stored   = 1'b0;
      status        = ST_IGNORED;
      case (kind)
         KIND_TICK: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 24'd1;
            end
         end
         KIND_OPEN: begin
            mode_in    = set_mode;
            count_in   = '0;
            confirm_in = 1'b0;
            if (!code_valid_ff && !set_mode) begin
               open_in = 1'b0;
               status  = ST_UNLOCKED;
            end else begin
               open_in = 1'b1;
               status  = ST_OPENED;
            end
         end
         KIND_DIGIT, KIND_ERASE, KIND_CANCEL: begin
            if (!open_ff) begin
               status = ST_IGNORED;
            end else if (wait_ff != '0) begin
               status = ST_BLOCKED;
            end else if (kind == KIND_DIGIT) begin
               if (digit <= MAX_DIGIT && count_ff < FULL_CNT) begin
                  write_entry = 1'b1;
                  count_in    = count_ff + CW'(1);
                  status      = ST_DIGIT;
                  if (count_ff == LAST_CNT) begin
                     count_in = '0;
                     if (mode_ff) begin
                        if (!confirm_ff) begin
                           load_first = 1'b1;
                           confirm_in = 1'b1;
                           status     = ST_CONFIRM;
                        end else if (match_first) begin
                           load_stored   = 1'b1;
                           code_valid_in = 1'b1;
                           open_in       = 1'b0;
                           confirm_in    = 1'b0;
                           status        = ST_STORED;
                        end else begin
                           confirm_in = 1'b0;
                           status     = ST_MISMATCH;
                        end
                     end else if (match_stored) begin
                        fail_in = '0;
                        wait_in = '0;
                        open_in = 1'b0;
                        status  = ST_UNLOCKED;
                     end else begin
                        fail_in = fail_inc;
                        // hard limit wins over soft
                        if (fail_inc >= cfg.hard_limit) begin
                           wait_in = cfg.hard_wait;
                        end else if (fail_inc >= cfg.soft_limit) begin
                           wait_in = cfg.soft_wait;
                        end
                        status = ST_WRONG;
                     end
                  end
               end
            end else if (kind == KIND_ERASE) begin
               if (count_ff != '0) begin
                  count_in = count_ff - CW'(1);
               end
               status = ST_ERASED;
            end else if (mode_ff) begin
               open_in    = 1'b0;
               count_in   = '0;
               confirm_in = 1'b0;
               status     = ST_CANCELLED;
            end
         end
         default: begin
            status = ST_IGNORED;
         end
      endcase
   end

   always_comb begin
      result.status         = status;
      result.digits_entered = COUNT_W'(count_in);
      result.locked_out     = (wait_in != '0);
      result.wait_left      = wait_in;
      result.failures       = fail_in;
      result.code_is_set    = code_valid_in;
      result.session_live   = open_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_valid_ff <= 1'b0;
         count_ff      <= '0;
         confirm_ff    <= 1'b0;
         mode_ff       <= 1'b0;
         open_ff       <= 1'b0;
         fail_ff       <= '0;
         wait_ff       <= '0;
      end else if (step) begin
         code_valid_ff <= code_valid_in;
         count_ff      <= count_in;
         confirm_ff    <= confirm_in;
         mode_ff       <= mode_in;
         open_ff       <= open_in;
         fail_ff       <= fail_in;
         wait_ff       <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && write_entry) begin
         entry_ff[count_ff[IW-1:0]] <= digit;
      end
      if (step && load_first) begin
         first_ff <= cand;
      end
      if (step && load_stored) begin
         stored_ff <= cand;
      end
   end

endmodule

>>> hw/rtl/pin_entry_lockout_controller_unit.sv
// ---------------------------------------------------------------------------
// pin_entry_lockout_controller_unit
// Keypad code entry with failure counting and timed lockout.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one word per keypad event or millisecond tick (kind, digit,
//            session_mode); taken when req_valid is high and req_stall low.
//   rsp_*  : exactly one result word per request word, in order, showing
//            the status and the state after that event.
//   csr_*  : limit and lockout length writes; csr_ready is always high.
//            Write only while no request word is in flight.
// Path: a taken word is held in the request register, processed by the
//   core step and registered in the result register that drives rsp_*.
// Throughput: one word per cycle unless rsp_stall holds a result; the step is
//   a single pass of compare and count logic between the two registers.
// Stall: while rsp_stall holds a result, the request register keeps one
//   more word and req_stall rises only once that register is also full.
// Reset: session closed, no code stored, failures and lockout cleared,
//   limits back to 4 and 6, lockout lengths to 30000 and 300000 ticks.
// ---------------------------------------------------------------------------
`include "pin_entry_lockout_controller_unit_macros.svh"

module pin_entry_lockout_controller_unit import pelc_pkg::*; #(
   parameter int CODE_DIGITS = DEF_CODE_DIGITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [DIGIT_W-1:0]   req_digit,
   input  logic                 req_session_mode,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_digits_entered,
   output logic                 rsp_locked_out,
   output logic [WAIT_W-1:0]    rsp_wait_left,
   output logic [LIMIT_W-1:0]   rsp_failures,
   output logic                 rsp_code_is_set,
   output logic                 rsp_session_live,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WAIT_W-1:0]    csr_wdata
);

   cfg_type            cfg;
   result_type         result;
   result_type         rsp_ff;
   logic               rsp_valid_ff;
   logic               stage_valid_ff;
   logic [KIND_W-1:0]  stage_kind_ff;
   logic [DIGIT_W-1:0] stage_digit_ff;
   logic               stage_mode_ff;
   logic               out_busy;
   logic               advance;

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign advance   = stage_valid_ff && !out_busy;
   assign req_stall = stage_valid_ff && out_busy;

   pelc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pelc_core #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .kind     (stage_kind_ff),
      .digit    (stage_digit_ff),
      .set_mode (stage_mode_ff),
      .cfg      (cfg),
      .result   (result)
   );

   // request register: load whenever not holding a stalled word
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_kind_ff  <= req_kind;
         stage_digit_ff <= req_digit;
         stage_mode_ff  <= req_session_mode;
      end
   end

   // result register: hold while stalled, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_digits_entered = rsp_ff.digits_entered;
   assign rsp_locked_out     = rsp_ff.locked_out;
   assign rsp_wait_left      = rsp_ff.wait_left;
   assign rsp_failures       = rsp_ff.failures;
   assign rsp_code_is_set    = rsp_ff.code_is_set;
   assign rsp_session_live   = rsp_ff.session_live;

   `PELC_ASSERT_IMPL(a_stall_needs_word, clock, reset, req_stall, stage_valid_ff, "stall with empty request register")
   `PELC_ASSERT_NEXT(a_advance_gives_rsp, clock, reset, advance, rsp_valid_ff, "processed word produced no result")
   `PELC_ASSERT_IMPL(a_lockout_flag, clock, reset, rsp_valid_ff, rsp_locked_out == (rsp_wait_left != '0), "locked_out disagrees with wait_left")
   `PELC_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid_ff, rsp_digits_entered < COUNT_W'(CODE_DIGITS), "entry count past code length")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad code-entry controller. A behavioral
// copy of the entry, code store and failure/lockout logic predicts every
// result word. Stimulus is a short scripted walk through the key cases,
// then randomized sessions under several limit settings, with random
// gaps on the request side and stalls on the result side.
// ---------------------------------------------------------------------------
module testbench;
   import pelc_pkg::*;

   localparam int CODE_LEN          = DEF_CODE_DIGITS;
   localparam int PIN_IDX_W         = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
   localparam int HALF_PERIOD       = 5;
   localparam int RESET_CYCLES      = 6;
   localparam int HOLD_CYCLES       = 60;
   localparam int QUIET_LIMIT       = 2000;
   localparam int DRAIN_CYCLES      = 4;
   localparam int END_CYCLES        = 10;
   localparam int REPORT_MAX        = 10;
   localparam int SATURATE_ATTEMPTS = 257;
   localparam logic [KIND_W-1:0]  KIND_SPARE_TOP = 3'd7;
   localparam logic [WAIT_W-1:0]  WAIT_MAX       = 24'hFFFFFF;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX      = 8'd255;
   localparam logic [LIMIT_W-1:0] LIMIT_MIN      = 8'd1;

   typedef logic [CODE_LEN-1:0][DIGIT_W-1:0] pin_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DIGIT_W-1:0] digit;
      logic               mode;
      logic               pinned;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } script_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [KIND_W-1:0]    req_kind;
   logic [DIGIT_W-1:0]   req_digit;
   logic                 req_session_mode;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_digits_entered;
   logic                 rsp_locked_out;
   logic [WAIT_W-1:0]    rsp_wait_left;
   logic [LIMIT_W-1:0]   rsp_failures;
   logic                 rsp_code_is_set;
   logic                 rsp_session_live;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WAIT_W-1:0]    csr_wdata;

   // behavioral copy of the controller
   cfg_type            limits_now;
   pin_type            pin_on_file;
   pin_type            pin_typed;
   pin_type            pin_first;
   logic               pin_saved;
   logic [COUNT_W-1:0] keys_held;
   logic               confirming;
   logic               set_session;
   logic               session_up;
   logic [LIMIT_W-1:0] fail_tally;
   logic [WAIT_W-1:0]  lock_ticks;

   result_type     outcomes_due[$];
   script_row_type script[$];
   result_type     seen_word;
   result_type     due_word;

   int          miscompares;
   int          words_with_effect;
   int          quiet_cycles;
   int          calm_left;
   int          free_left;
   bit          no_gaps;
   bit          squeeze_req;
   bit          squeeze_on;
   bit          pin_active;
   status_type  pin_status;
   logic [COUNT_W-1:0] pin_count;

   pin_entry_lockout_controller_unit #(
      .CODE_DIGITS(CODE_LEN)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_digit          (req_digit),
      .req_session_mode   (req_session_mode),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_digits_entered (rsp_digits_entered),
      .rsp_locked_out     (rsp_locked_out),
      .rsp_wait_left      (rsp_wait_left),
      .rsp_failures       (rsp_failures),
      .rsp_code_is_set    (rsp_code_is_set),
      .rsp_session_live   (rsp_session_live),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   function automatic result_type keypad_outcome(input logic [KIND_W-1:0] k,
                                                 input logic [DIGIT_W-1:0] d,
                                                 input logic m);
      result_type r;
      status_type st;
      st = ST_IGNORED;
      if (k == KIND_TICK) begin
         if (lock_ticks != 0) lock_ticks = lock_ticks - 1'b1;
      end else if (k == KIND_OPEN) begin
         set_session = m;
         keys_held   = '0;
         confirming  = 1'b0;
         if (!pin_saved && !m) begin
            session_up = 1'b0;
            st = ST_UNLOCKED;
         end else begin
            session_up = 1'b1;
            st = ST_OPENED;
         end
      end else if (k <= KIND_CANCEL && session_up) begin
         if (lock_ticks != 0) begin
            st = ST_BLOCKED;
         end else if (k == KIND_DIGIT) begin
            if (d <= MAX_DIGIT && keys_held < CODE_LEN) begin
               pin_typed[keys_held[PIN_IDX_W-1:0]] = d;
               keys_held = keys_held + 1'b1;
               st = ST_DIGIT;
               // full buffer: check it at once
               if (keys_held == CODE_LEN) begin
                  keys_held = '0;
                  if (set_session && !confirming) begin
                     pin_first  = pin_typed;
                     confirming = 1'b1;
                     st = ST_CONFIRM;
                  end else if (set_session) begin
                     confirming = 1'b0;
                     if (pin_first == pin_typed) begin
                        pin_on_file = pin_typed;
                        pin_saved   = 1'b1;
                        session_up  = 1'b0;
                        st = ST_STORED;
                     end else begin
                        st = ST_MISMATCH;
                     end
                  end else if (pin_on_file == pin_typed) begin
                     fail_tally = '0;
                     lock_ticks = '0;
                     session_up = 1'b0;
                     st = ST_UNLOCKED;
                  end else begin
                     if (fail_tally != FAIL_SAT) fail_tally = fail_tally + 1'b1;
                     // hard limit wins over the soft one
                     if (fail_tally >= limits_now.hard_limit)
                        lock_ticks = limits_now.hard_wait;
                     else if (fail_tally >= limits_now.soft_limit)
                        lock_ticks = limits_now.soft_wait;
                     st = ST_WRONG;
                  end
               end
            end
         end else if (k == KIND_ERASE) begin
            if (keys_held != 0) keys_held = keys_held - 1'b1;
            st = ST_ERASED;
         end else if (set_session) begin
            session_up = 1'b0;
            keys_held  = '0;
            confirming = 1'b0;
            st = ST_CANCELLED;
         end
      end
      r.status         = st;
      r.digits_entered = keys_held;
      r.locked_out     = (lock_ticks != 0);
      r.wait_left      = lock_ticks;
      r.failures       = fail_tally;
      r.code_is_set    = pin_saved;
      r.session_live   = session_up;
      return r;
   endfunction

   function automatic pin_type random_pin();
      pin_type p;
      for (int i = 0; i < CODE_LEN; i++) p[i] = DIGIT_W'($urandom_range(0, 9));
      return p;
   endfunction

   function automatic logic any_mode();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [DIGIT_W-1:0] any_key();
      return DIGIT_W'($urandom_range(0, 15));
   endfunction

   function automatic script_row_type row(input logic [KIND_W-1:0] k,
                                          input logic [DIGIT_W-1:0] d,
                                          input logic m, input logic p,
                                          input status_type s,
                                          input logic [COUNT_W-1:0] c);
      script_row_type t;
      t.kind   = k;
      t.digit  = d;
      t.mode   = m;
      t.pinned = p;
      t.status = s;
      t.count  = c;
      return t;
   endfunction

   task automatic send_word(input logic [KIND_W-1:0] k, input logic [DIGIT_W-1:0] d,
                            input logic m);
      int gap;
      int r;
      logic [WAIT_W-1:0] wait_before;
      result_type want;
      gap = 0;
      if (calm_left != 0) begin
         calm_left--;
      end else if (!no_gaps) begin
         r = $urandom_range(0, 99);
         if (r < 2)
            calm_left = $urandom_range(20, 40);
         else if (r >= 60 && r < 95)
            gap = $urandom_range(1, 3);
         else if (r >= 95)
            gap = $urandom_range(8, 30);
      end
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_kind         = k;
      req_digit        = d;
      req_session_mode = m;
      do @(posedge clock); while (req_stall);
      wait_before = lock_ticks;
      want = keypad_outcome(k, d, m);
      if (pin_active) begin
         want.status         = pin_status;
         want.digits_entered = pin_count;
      end
      outcomes_due.push_back(want);
      if (want.status != ST_IGNORED || (k == KIND_TICK && wait_before != 0))
         words_with_effect++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (outcomes_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [WAIT_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SOFT_LIMIT: limits_now.soft_limit = val[LIMIT_W-1:0];
         REG_HARD_LIMIT: limits_now.hard_limit = val[LIMIT_W-1:0];
         REG_SOFT_WAIT:  limits_now.soft_wait  = val;
         REG_HARD_WAIT:  limits_now.hard_wait  = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] soft_lim,
                             input logic [LIMIT_W-1:0] hard_lim,
                             input logic [WAIT_W-1:0] soft_len,
                             input logic [WAIT_W-1:0] hard_len);
      settle();
      write_reg(REG_SOFT_LIMIT, WAIT_W'(soft_lim));
      write_reg(REG_HARD_LIMIT, WAIT_W'(hard_lim));
      write_reg(REG_SOFT_WAIT, soft_len);
      write_reg(REG_HARD_WAIT, hard_len);
   endtask

   task automatic key_pin(input pin_type pin, input bit may_erase);
      for (int i = 0; i < CODE_LEN; i++) begin
         send_word(KIND_DIGIT, pin[i], any_mode());
         if (may_erase && $urandom_range(0, 9) == 0) begin
            send_word(KIND_ERASE, any_key(), any_mode());
            send_word(KIND_DIGIT, pin[i], any_mode());
         end
      end
   endtask

   task automatic wait_out_lockout();
      while (lock_ticks != 0) send_word(KIND_TICK, any_key(), any_mode());
   endtask

   task automatic mixed_sessions(input int goal);
      int stop_at;
      int r;
      int n;
      pin_type pin;
      logic [KIND_W-1:0] k;
      stop_at = words_with_effect + goal;
      while (words_with_effect < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 30 && pin_saved) begin
            send_word(KIND_OPEN, any_key(), 1'b0);
            pin = ($urandom_range(0, 1) != 0) ? pin_on_file : random_pin();
            key_pin(pin, 1'b1);
         end else if (r < 50) begin
            send_word(KIND_OPEN, any_key(), 1'b1);
            pin = random_pin();
            if ($urandom_range(0, 9) == 0) begin
               n = $urandom_range(0, CODE_LEN - 1);
               for (int i = 0; i < n; i++) send_word(KIND_DIGIT, pin[i], any_mode());
               send_word(KIND_CANCEL, any_key(), any_mode());
            end else begin
               key_pin(pin, 1'b1);
               if ($urandom_range(0, 9) < 7) key_pin(pin, 1'b1);
               else key_pin(random_pin(), 1'b1);
            end
         end else if (r < 62) begin
            if (lock_ticks != 0) begin
               // count the lockout down, poking keys now and then
               while (lock_ticks != 0) begin
                  if ($urandom_range(0, 6) == 0)
                     k = KIND_W'($urandom_range(KIND_DIGIT, KIND_CANCEL));
                  else
                     k = KIND_TICK;
                  send_word(k, any_key(), any_mode());
               end
            end else begin
               repeat ($urandom_range(1, 3))
                  send_word(KIND_TICK, any_key(), any_mode());
            end
         end else if (r < 75) begin
            repeat ($urandom_range(1, CODE_LEN))
               send_word(KIND_DIGIT, DIGIT_W'($urandom_range(0, 9)), any_mode());
         end else begin
            k = KIND_W'($urandom_range(0, 7));
            send_word(k, any_key(), any_mode());
         end
      end
   endtask

   // drive the failure count into saturation with no lockout configured
   task automatic exhaust_attempts();
      pin_type pin;
      wait_out_lockout();
      if (!pin_saved) begin
         send_word(KIND_OPEN, '0, 1'b1);
         pin = random_pin();
         key_pin(pin, 1'b0);
         key_pin(pin, 1'b0);
      end
      send_word(KIND_OPEN, '0, 1'b0);
      repeat (SATURATE_ATTEMPTS) begin
         pin = random_pin();
         if (pin == pin_on_file) pin[0] = (pin[0] == MAX_DIGIT) ? '0 : pin[0] + 1'b1;
         key_pin(pin, 1'b0);
      end
      send_word(KIND_OPEN, '0, 1'b0);
      key_pin(pin_on_file, 1'b0);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall  = 1'b0;
      squeeze_on = 1'b0;
      free_left  = 0;
      forever begin
         @(negedge clock);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            squeeze_on  = 1'b1;
            rsp_stall   = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall  = 1'b0;
            squeeze_on = 1'b0;
         end else if (free_left != 0) begin
            free_left--;
         end else if (rsp_stall) begin
            rsp_stall = 1'b0;
            free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                    : $urandom_range(0, 6);
         end else begin
            rsp_stall = 1'b1;
            case ($urandom_range(0, 99)) inside
               [0:79]:  free_left = $urandom_range(0, 1);
               [80:96]: free_left = $urandom_range(2, 5);
               default: free_left = $urandom_range(15, 40);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_word.status         = rsp_status;
         seen_word.digits_entered = rsp_digits_entered;
         seen_word.locked_out     = rsp_locked_out;
         seen_word.wait_left      = rsp_wait_left;
         seen_word.failures       = rsp_failures;
         seen_word.code_is_set    = rsp_code_is_set;
         seen_word.session_live   = rsp_session_live;
         if (outcomes_due.size() == 0) begin
            miscompares++;
            if (miscompares <= REPORT_MAX)
               $display("%0t: result word with none pending, status %0d", $realtime,
                        rsp_status);
         end else begin
            due_word = outcomes_due.pop_front();
            if (seen_word.status         !== due_word.status         ||
                seen_word.digits_entered !== due_word.digits_entered ||
                seen_word.locked_out     !== due_word.locked_out     ||
                seen_word.wait_left      !== due_word.wait_left      ||
                seen_word.failures       !== due_word.failures       ||
                seen_word.code_is_set    !== due_word.code_is_set    ||
                seen_word.session_live   !== due_word.session_live) begin
               miscompares++;
               if (miscompares <= REPORT_MAX)
                  $display("%0t: mismatch (expected/actual) status %0d/%0d digits %0d/%0d",
                           $realtime,
                           due_word.status, seen_word.status,
                           due_word.digits_entered, seen_word.digits_entered,
                           " locked %0d/%0d wait %0d/%0d failures %0d/%0d",
                           due_word.locked_out, seen_word.locked_out,
                           due_word.wait_left, seen_word.wait_left,
                           due_word.failures, seen_word.failures,
                           " code %0d/%0d live %0d/%0d",
                           due_word.code_is_set, seen_word.code_is_set,
                           due_word.session_live, seen_word.session_live);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      pin_type pin;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_TICK;
      req_digit        = '0;
      req_session_mode = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = REG_SOFT_LIMIT;
      csr_wdata        = '0;
      miscompares       = 0;
      words_with_effect = 0;
      quiet_cycles      = 0;
      calm_left         = 0;
      no_gaps           = 1'b0;
      squeeze_req       = 1'b0;
      pin_active        = 1'b0;
      pin_status        = ST_IGNORED;
      pin_count         = '0;
      limits_now.soft_limit = RST_SOFT_LIMIT;
      limits_now.hard_limit = RST_HARD_LIMIT;
      limits_now.soft_wait  = RST_SOFT_WAIT;
      limits_now.hard_wait  = RST_HARD_WAIT;
      pin_on_file = '0;
      pin_typed   = '0;
      pin_first   = '0;
      pin_saved   = 1'b0;
      keys_held   = '0;
      confirming  = 1'b0;
      set_session = 1'b0;
      session_up  = 1'b0;
      fail_tally  = '0;
      lock_ticks  = '0;

      script.push_back(row(KIND_TICK,      4'd0,  1'b0, 1'b1, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd5,  1'b0, 1'b1, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_OPEN,      4'd0,  1'b0, 1'b1, ST_UNLOCKED,  5'd0));
      script.push_back(row(KIND_OPEN,      4'd0,  1'b1, 1'b1, ST_OPENED,    5'd0));
      script.push_back(row(KIND_ERASE,     4'd0,  1'b0, 1'b1, ST_ERASED,    5'd0));
      script.push_back(row(KIND_DIGIT,     4'd15, 1'b1, 1'b1, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd9,  1'b0, 1'b1, ST_DIGIT,     5'd1));
      script.push_back(row(KIND_DIGIT,     4'd0,  1'b0, 1'b1, ST_DIGIT,     5'd2));
      script.push_back(row(KIND_ERASE,     4'd15, 1'b1, 1'b1, ST_ERASED,    5'd1));
      script.push_back(row(KIND_DIGIT,     4'd0,  1'b0, 1'b0, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd7,  1'b0, 1'b0, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd3,  1'b0, 1'b1, ST_CONFIRM,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd9,  1'b1, 1'b0, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd0,  1'b1, 1'b0, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd7,  1'b1, 1'b0, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd3,  1'b1, 1'b1, ST_STORED,    5'd0));
      script.push_back(row(KIND_CANCEL,    4'd0,  1'b1, 1'b1, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_SPARE_TOP, 4'd9,  1'b1, 1'b1, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_OPEN,      4'd0,  1'b0, 1'b1, ST_OPENED,    5'd0));
      script.push_back(row(KIND_CANCEL,    4'd0,  1'b0, 1'b1, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd1,  1'b0, 1'b0, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd2,  1'b0, 1'b0, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd3,  1'b0, 1'b0, ST_IGNORED,   5'd0));
      script.push_back(row(KIND_DIGIT,     4'd4,  1'b0, 1'b1, ST_WRONG,     5'd0));
      script.push_back(row(KIND_OPEN,      4'd0,  1'b1, 1'b1, ST_OPENED,    5'd0));
      script.push_back(row(KIND_CANCEL,    4'd0,  1'b0, 1'b1, ST_CANCELLED, 5'd0));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         pin_active = script[i].pinned;
         pin_status = script[i].status;
         pin_count  = script[i].count;
         send_word(script[i].kind, script[i].digit, script[i].mode);
      end
      pin_active = 1'b0;

      // soft then hard lockout; hold the result side long while words keep coming
      set_limits(8'd2, 8'd3, 24'd7, 24'd20);
      squeeze_req = 1'b1;
      while (!squeeze_on) @(negedge clock);
      no_gaps = 1'b1;
      mixed_sessions(35);
      no_gaps = 1'b0;
      mixed_sessions(120);

      set_limits(LIMIT_MIN, LIMIT_MAX, 24'd3, 24'd12);
      mixed_sessions(120);

      set_limits(LIMIT_MAX, LIMIT_MIN, WAIT_MAX, 24'd9);
      mixed_sessions(120);

      set_limits(8'd3, 8'd5, '0, '0);
      exhaust_attempts();
      mixed_sessions(80);

      set_limits(8'd3, 8'd2, 24'd15, 24'd6);
      mixed_sessions(120);

      // longest lockout: enter it and poke at it until the end
      wait_out_lockout();
      set_limits(LIMIT_MIN, LIMIT_MIN, WAIT_MAX, WAIT_MAX);
      send_word(KIND_OPEN, '0, 1'b0);
      pin = pin_on_file;
      pin[0] = (pin[0] == MAX_DIGIT) ? '0 : pin[0] + 1'b1;
      key_pin(pin, 1'b0);
      send_word(KIND_TICK, 4'd15, 1'b1);
      send_word(KIND_DIGIT, MAX_DIGIT, 1'b0);
      send_word(KIND_ERASE, '0, 1'b0);
      send_word(KIND_CANCEL, '0, 1'b1);
      send_word(KIND_OPEN, '0, 1'b1);
      send_word(KIND_CANCEL, '0, 1'b0);
      send_word(KIND_SPARE_TOP, 4'd15, 1'b1);
      send_word(KIND_TICK, '0, 1'b0);

      @(negedge clock);
      req_valid = 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (outcomes_due.size() != 0) begin
         $display("%0d expected result words never arrived", outcomes_due.size());
         miscompares += outcomes_due.size();
      end
      if (miscompares == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
